// ----- rtl/core/chp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chp_pkg
// Types, register indexes, constants and small helpers for the caldera
// height pixel core.
// ----------------------------------------------------------------------------
package chp_pkg;

	// raster size bound for pixel and center coordinates
	localparam int unsigned MAX_DIM = 4096;

	// one in Q1.15 level registers
	localparam logic [15:0] LEVEL_ONE = 16'h8000;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		CFG_CENTER_COL         = 3'd0,
		CFG_CENTER_ROW         = 3'd1,
		CFG_RIM_RADIUS         = 3'd2,
		CFG_INNER_SIGMA        = 3'd3,
		CFG_OUTER_SIGMA        = 3'd4,
		CFG_BOTTOM_LEVEL       = 3'd5,
		CFG_RADIAL_NOISE_AMP   = 3'd6,
		CFG_HEIGHT_NOISE_RATIO = 3'd7
	} chp_cfg_idx_t;

	// input word: one pixel
	typedef struct packed {
		logic [11:0] pixel_col;
		logic [11:0] pixel_row;
		logic [15:0] noise_level;
	} chp_in_t;

	// output word: one height
	typedef struct packed {
		logic [16:0] height;
		logic        inside_rim;
	} chp_out_t;

	// exp(-2^(k-16)) in Q30
	function automatic logic [29:0] exp_bit_q30(input int k);
		logic [29:0] c;
		case (k)
			0:  c = 30'd1073725440;
			1:  c = 30'd1073709056;
			2:  c = 30'd1073676290;
			3:  c = 30'd1073610760;
			4:  c = 30'd1073479712;
			5:  c = 30'd1073217664;
			6:  c = 30'd1072693760;
			7:  c = 30'd1071646719;
			8:  c = 30'd1069555701;
			9:  c = 30'd1065385899;
			10: c = 30'd1057095000;
			11: c = 30'd1040706261;
			12: c = 30'd1008687096;
			13: c = 30'd947573834;
			14: c = 30'd836230973;
			15: c = 30'd651257337;
			16: c = 30'd395007542;
			17: c = 30'd145315154;
			18: c = 30'd19666268;
			19: c = 30'd360200;
			default: c = 30'd0;
		endcase
		return c;
	endfunction

	// coordinates past the raster are pulled to its last pixel
	function automatic logic [11:0] clamp_coord(input logic [11:0] v);
		logic [16:0] lim;
		lim = 17'(MAX_DIM);
		if ({5'b0, v} >= lim)
			return 12'(MAX_DIM - 1);
		return v;
	endfunction

	// levels above one are used as one
	function automatic logic [15:0] clamp_level(input logic [15:0] v);
		return (v > LEVEL_ONE) ? LEVEL_ONE : v;
	endfunction

	// a zero width is used as the smallest step
	function automatic logic [19:0] nonzero_sigma(input logic [19:0] v);
		return (v == 20'd0) ? 20'd1 : v;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/caldera_height_pixel_core.sv -----
`default_nettype none
// Throughput: one pixel per cycle while the skid stage is empty; the sqrt,
// divide and exp chains are fully pipelined, one result bit or one exp
// factor per stage.
// Reset: all valid bits clear, registers take their reset values
// (inner and outer sigma 1.0, all others zero); no clearing pass.
// ----------------------------------------------------------------------------
// caldera_height_pixel_core
// Caldera height per raster pixel: rim distance via pipelined square root,
// shared restoring divider for the Gaussian exponent or the Lorentzian
// falloff, product-of-constants exp, noise scaling and saturation.
// ----------------------------------------------------------------------------
module caldera_height_pixel_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pix_valid,
	output logic                   pix_stall,
	input  wire chp_pkg::chp_in_t  pix,
	output logic                   hgt_valid,
	input  wire logic              hgt_stall,
	output chp_pkg::chp_out_t      hgt,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [19:0]       cfg_data
);
	import chp_pkg::*;

	localparam int SQ_STEPS = 21;
	localparam int DV_STEPS = 20;
	localparam int EX_STEPS = 20;

	// configuration registers
	logic [11:0] center_col_q, center_row_q;
	logic [19:0] rim_radius_q, inner_sigma_q, outer_sigma_q, radial_noise_amp_q;
	logic [15:0] bottom_level_q, height_noise_ratio_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q         <= '0;
			center_row_q         <= '0;
			rim_radius_q         <= '0;
			inner_sigma_q        <= 20'd256;
			outer_sigma_q        <= 20'd256;
			bottom_level_q       <= '0;
			radial_noise_amp_q   <= '0;
			height_noise_ratio_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (chp_cfg_idx_t'(cfg_index))
				CFG_CENTER_COL:         center_col_q         <= cfg_data[11:0];
				CFG_CENTER_ROW:         center_row_q         <= cfg_data[11:0];
				CFG_RIM_RADIUS:         rim_radius_q         <= cfg_data;
				CFG_INNER_SIGMA:        inner_sigma_q        <= cfg_data;
				CFG_OUTER_SIGMA:        outer_sigma_q        <= cfg_data;
				CFG_BOTTOM_LEVEL:       bottom_level_q       <= cfg_data[15:0];
				CFG_RADIAL_NOISE_AMP:   radial_noise_amp_q   <= cfg_data;
				CFG_HEIGHT_NOISE_RATIO: height_noise_ratio_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// pipeline advance: held only while the skid stage is full
	logic en;
	logic skid_v_q;
	assign en        = !skid_v_q;
	assign pix_stall = !en;

	// ---------------- stage 1: offsets and signed noise
	logic               v_s1;
	logic signed [12:0] dx_s1, dy_s1;
	logic signed [17:0] sn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= pix_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({1'b0, clamp_coord(pix.pixel_col)})
				- $signed({1'b0, clamp_coord(center_col_q)});
			dy_s1 <= $signed({1'b0, clamp_coord(pix.pixel_row)})
				- $signed({1'b0, clamp_coord(center_row_q)});
			sn_s1 <= $signed({1'b0, pix.noise_level, 1'b0}) - 18'sd65536;
		end
	end

	// ---------------- stage 2: squares and noise products
	logic               v_s2;
	logic [23:0]        dx2_s2, dy2_s2;
	logic signed [38:0] pd_s2;
	logic signed [34:0] pf_s2;
	logic signed [25:0] dxx_c, dyy_c;
	logic signed [38:0] pd_c;
	logic signed [34:0] pf_c;

	assign dxx_c = dx_s1 * dx_s1;
	assign dyy_c = dy_s1 * dy_s1;
	assign pd_c  = $signed({1'b0, radial_noise_amp_q}) * sn_s1;
	assign pf_c  = $signed({1'b0, clamp_level(height_noise_ratio_q)}) * sn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx2_s2 <= dxx_c[23:0];
			dy2_s2 <= dyy_c[23:0];
			pd_s2  <= pd_c;
			pf_s2  <= pf_c;
		end
	end

	// ---------------- stage 3: squared distance, displacement, noise factor
	logic                sq_v_s    [SQ_STEPS+1];
	logic [40:0]         sq_rem_s  [SQ_STEPS+1];
	logic [41:0]         sq_res_s  [SQ_STEPS+1];
	logic signed [21:0]  sq_disp_s [SQ_STEPS+1];
	logic [16:0]         sq_f_s    [SQ_STEPS+1];

	logic [24:0]        d2_c;
	logic signed [38:0] pdr_c;
	logic signed [34:0] pfr_c;
	logic signed [18:0] fsum_c;

	assign d2_c   = {1'b0, dx2_s2} + {1'b0, dy2_s2};
	assign pdr_c  = pd_s2 + 39'sd32768;
	assign pfr_c  = pf_s2 + 35'sd16384;
	assign fsum_c = 19'sd65536 + {pfr_c[32], pfr_c[32:15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_v_s[0] <= 1'b0;
		else if (en)
			sq_v_s[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem_s[0]  <= {d2_c, 16'b0};
			sq_res_s[0]  <= '0;
			sq_disp_s[0] <= pdr_c[37:16];
			sq_f_s[0]    <= fsum_c[16:0];
		end
	end

	// ---------------- square root, one result bit per stage
	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		localparam logic [41:0] BIT = 42'd1 << (2 * (SQ_STEPS - 1 - i));
		logic [42:0] trial;
		logic        ge;

		assign trial = {1'b0, sq_res_s[i]} + {1'b0, BIT};
		assign ge    = {2'b0, sq_rem_s[i]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s[i+1] <= 1'b0;
			else if (en)
				sq_v_s[i+1] <= sq_v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[i+1]  <= ge ? (sq_rem_s[i] - trial[40:0]) : sq_rem_s[i];
				sq_res_s[i+1]  <= ge ? ((sq_res_s[i] >> 1) + BIT) : (sq_res_s[i] >> 1);
				sq_disp_s[i+1] <= sq_disp_s[i];
				sq_f_s[i+1]    <= sq_f_s[i];
			end
		end
	end

	// ---------------- stage 4: signed rim distance and its magnitude
	logic               v_s4, inside_s4;
	logic [21:0]        ra_s4;
	logic [16:0]        f_s4;
	logic signed [23:0] r_c;
	logic signed [23:0] ra_c;

	assign r_c = $signed({3'b0, sq_res_s[SQ_STEPS][20:0]})
		- $signed({4'b0, rim_radius_q})
		+ {{2{sq_disp_s[SQ_STEPS][21]}}, sq_disp_s[SQ_STEPS]};
	assign ra_c = r_c[23] ? -r_c : r_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= sq_v_s[SQ_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s4 <= r_c[23];
			ra_s4     <= ra_c[21:0];
			f_s4      <= sq_f_s[SQ_STEPS];
		end
	end

	// ---------------- stage 5: r^2 and sigma squares
	logic        v_s5, inside_s5;
	logic [43:0] r2_s5;
	logic [39:0] si2_s5, so2_s5;
	logic [16:0] f_s5;
	logic [19:0] si_c, so_c;

	assign si_c = nonzero_sigma(inner_sigma_q);
	assign so_c = nonzero_sigma(outer_sigma_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s5 <= inside_s4;
			r2_s5     <= ra_s4 * ra_s4;
			si2_s5    <= si_c * si_c;
			so2_s5    <= so_c * so_c;
			f_s5      <= f_s4;
		end
	end

	// ---------------- stage 6: outer denominator, exponent range check
	logic        v_s6, inside_s6, ovf_s6;
	logic [43:0] r2_s6;
	logic [39:0] si2_s6, so2_s6;
	logic [44:0] den_s6;
	logic [16:0] f_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s6 <= inside_s5;
			// exponent of 16.0 or more gives zero
			ovf_s6    <= {1'b0, r2_s5} >= {si2_s5, 5'b0};
			r2_s6     <= r2_s5;
			si2_s6    <= si2_s5;
			so2_s6    <= so2_s5;
			den_s6    <= {5'b0, so2_s5} + {1'b0, r2_s5};
			f_s6      <= f_s5;
		end
	end

	// ---------------- stage 7: divider operands
	logic        dv_v_s      [DV_STEPS+1];
	logic [44:0] dv_rem_s    [DV_STEPS+1];
	logic [19:0] dv_nlo_s    [DV_STEPS+1];
	logic [44:0] dv_d_s      [DV_STEPS+1];
	logic [19:0] dv_q_s      [DV_STEPS+1];
	logic        dv_inside_s [DV_STEPS+1];
	logic        dv_ovf_s    [DV_STEPS+1];
	logic [16:0] dv_f_s      [DV_STEPS+1];

	logic [59:0] num_c;
	logic [44:0] dsr_c;

	always_comb begin
		if (inside_s6) begin
			dsr_c = {4'b0, si2_s6, 1'b0};
			num_c = ovf_s6 ? '0 : {r2_s6, 16'b0};
		end else begin
			dsr_c = den_s6;
			num_c = {4'b0, so2_s6, 16'b0} + {16'b0, den_s6[44:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v_s[0] <= 1'b0;
		else if (en)
			dv_v_s[0] <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0]    <= {5'b0, num_c[59:20]};
			dv_nlo_s[0]    <= num_c[19:0];
			dv_d_s[0]      <= dsr_c;
			dv_q_s[0]      <= '0;
			dv_inside_s[0] <= inside_s6;
			dv_ovf_s[0]    <= ovf_s6;
			dv_f_s[0]      <= f_s6;
		end
	end

	// ---------------- restoring divider, one quotient bit per stage
	for (genvar i = 0; i < DV_STEPS; i++) begin : g_div
		logic [45:0] tr;
		logic [45:0] sub;
		logic        ge;

		assign tr  = {dv_rem_s[i], dv_nlo_s[i][DV_STEPS-1-i]};
		assign ge  = tr >= {1'b0, dv_d_s[i]};
		assign sub = tr - {1'b0, dv_d_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[i+1] <= 1'b0;
			else if (en)
				dv_v_s[i+1] <= dv_v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[i+1]    <= ge ? sub[44:0] : tr[44:0];
				dv_nlo_s[i+1]    <= dv_nlo_s[i];
				dv_d_s[i+1]      <= dv_d_s[i];
				dv_q_s[i+1]      <= {dv_q_s[i][18:0], ge};
				dv_inside_s[i+1] <= dv_inside_s[i];
				dv_ovf_s[i+1]    <= dv_ovf_s[i];
				dv_f_s[i+1]      <= dv_f_s[i];
			end
		end
	end

	// ---------------- exp start
	logic        ex_v_s      [EX_STEPS+1];
	logic [30:0] ex_acc_s    [EX_STEPS+1];
	logic [19:0] ex_t_s      [EX_STEPS+1];
	logic        ex_inside_s [EX_STEPS+1];
	logic        ex_ovf_s    [EX_STEPS+1];
	logic [16:0] ex_f_s      [EX_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ex_v_s[0] <= 1'b0;
		else if (en)
			ex_v_s[0] <= dv_v_s[DV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex_acc_s[0]    <= 31'h4000_0000;
			ex_t_s[0]      <= dv_q_s[DV_STEPS];
			ex_inside_s[0] <= dv_inside_s[DV_STEPS];
			ex_ovf_s[0]    <= dv_ovf_s[DV_STEPS];
			ex_f_s[0]      <= dv_f_s[DV_STEPS];
		end
	end

	// ---------------- exp(-t): one constant factor per exponent bit
	for (genvar k = 0; k < EX_STEPS; k++) begin : g_exp
		localparam logic [29:0] CST = exp_bit_q30(k);
		logic [60:0] pr;

		assign pr = ex_acc_s[k] * CST + 61'h2000_0000;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				ex_v_s[k+1] <= 1'b0;
			else if (en)
				ex_v_s[k+1] <= ex_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ex_acc_s[k+1]    <= ex_t_s[k][k] ? pr[60:30] : ex_acc_s[k];
				ex_t_s[k+1]      <= ex_t_s[k];
				ex_inside_s[k+1] <= ex_inside_s[k];
				ex_ovf_s[k+1]    <= ex_ovf_s[k];
				ex_f_s[k+1]      <= ex_f_s[k];
			end
		end
	end

	// ---------------- stage 8: exp back to Q.16
	logic        v_s8, inside_s8;
	logic [16:0] e_s8, zq_s8, f_s8;
	logic [30:0] er_c;

	assign er_c = ex_acc_s[EX_STEPS] + 31'd8192;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (en)
			v_s8 <= ex_v_s[EX_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s8 <= ex_inside_s[EX_STEPS];
			e_s8      <= (ex_inside_s[EX_STEPS] && !ex_ovf_s[EX_STEPS]) ? er_c[30:14] : '0;
			zq_s8     <= ex_t_s[EX_STEPS][16:0];
			f_s8      <= ex_f_s[EX_STEPS];
		end
	end

	// ---------------- stage 9: blend toward the floor inside the rim
	logic        v_s9, inside_s9;
	logic [16:0] z_s9, f_s9;
	logic [16:0] b_c;
	logic [33:0] ez_c;

	assign b_c  = {clamp_level(bottom_level_q), 1'b0};
	assign ez_c = e_s8 * (17'h10000 - b_c) + 34'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (en)
			v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s9 <= inside_s8;
			z_s9      <= inside_s8 ? (b_c + ez_c[32:16]) : zq_s8;
			f_s9      <= f_s8;
		end
	end

	// ---------------- stage 10: noise scaling product
	logic        v_s10, inside_s10;
	logic [33:0] hp_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s10 <= 1'b0;
		else if (en)
			v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s10 <= inside_s9;
			hp_s10     <= z_s9 * f_s9;
		end
	end

	// ---------------- stage 11: round and saturate
	logic        v_s11;
	chp_out_t    res_s11;
	logic [34:0] hr_c;

	assign hr_c = {1'b0, hp_s10} + 35'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s11 <= 1'b0;
		else if (en)
			v_s11 <= v_s10;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s11.height     <= (hr_c[34:33] != 2'b00) ? 17'h1FFFF : hr_c[32:16];
			res_s11.inside_rim <= inside_s10;
		end
	end

	// ---------------- output register and skid stage
	logic     out_v_q;
	chp_out_t out_q, skid_q;
	logic     take, arrive;

	assign take   = out_v_q && !hgt_stall;
	assign arrive = v_s11 && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take)
				skid_v_q <= 1'b0;
		end else if (arrive) begin
			if (out_v_q && !take)
				skid_v_q <= 1'b1;
			else
				out_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take)
				out_q <= skid_q;
		end else if (arrive) begin
			if (out_v_q && !take)
				skid_q <= res_s11;
			else
				out_q <= res_s11;
		end
	end

	assign hgt_valid = out_v_q;
	assign hgt       = out_q;

	// ---------------- checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word held with empty output register");

	a_stalled_arrival_skids: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && hgt_stall && v_s11 && !skid_v_q) |=> skid_v_q)
		else $error("word arriving at a stalled output was not kept");

	a_outer_quotient_range: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_v_s[DV_STEPS] && !dv_inside_s[DV_STEPS]) |-> (dv_q_s[DV_STEPS] <= 20'h10000))
		else $error("outer falloff above one");

	a_exp_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		ex_v_s[EX_STEPS] |-> (ex_acc_s[EX_STEPS] <= 31'h4000_0000))
		else $error("exp accumulator above one");

endmodule
`default_nettype wire
